// ===== rtl/core/pwsr_pkg.sv =====
// ----------------------------------------------------------------------------
// pwsr_pkg: shared types and constants of the pulse width serial receiver
// Holds the phase codes, configuration indexes, queue sizing and the
// line sample type that travels from the front end to the decoder.
// ----------------------------------------------------------------------------
package pwsr_pkg;

  // Line sample classified by the front end
  typedef struct packed {
    logic level;  // sampled line value
    logic fall;   // high-to-low edge against the previous sample
  } sample_t;

  // Configuration register indexes
  localparam logic CFG_MAX_BYTES = 1'b0;
  localparam logic CFG_MAX_RUN   = 1'b1;

  // Configuration reset values
  localparam logic [7:0] MAX_BYTES_RESET = 8'd32;
  localparam logic [7:0] MAX_RUN_RESET   = 8'd255;

  // Decoder phase codes
  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_LEAD_LOW  = 3'd1;
  localparam logic [2:0] PH_REF0_HIGH = 3'd2;
  localparam logic [2:0] PH_REF0_GAP  = 3'd3;
  localparam logic [2:0] PH_REF1_HIGH = 3'd4;
  localparam logic [2:0] PH_BIT_GAP   = 3'd5;
  localparam logic [2:0] PH_BIT_HIGH  = 3'd6;

  // Pulses in one byte before the flag pulse
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // Sample queue between front end and decoder
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

// ===== rtl/core/pwsr_front.sv =====
// ----------------------------------------------------------------------------
// pwsr_front: line sample intake
// Accepts one line sample per transfer, marks falling edges against the
// previous sample and pushes the classified sample into the queue.
// ----------------------------------------------------------------------------
module pwsr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              line_level,
  input  logic              queue_full,
  output logic              push,
  output pwsr_pkg::sample_t push_sample
);

  logic previous_level;

  // Stall the line only while the queue has no room
  assign in_stall = queue_full;
  assign push     = in_valid & ~queue_full;

  // Classify the sample
  assign push_sample.level = line_level;
  assign push_sample.fall  = previous_level & ~line_level;

  // Track the last accepted level; the line idles high
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b1;
    end else if (push) begin
      previous_level <= line_level;
    end
  end

endmodule

// ===== rtl/core/pwsr_queue.sv =====
// ----------------------------------------------------------------------------
// pwsr_queue: sample queue
// Short first-in first-out buffer that decouples the sample intake from
// the decoder so that each side may stall on its own.
// ----------------------------------------------------------------------------
module pwsr_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pwsr_pkg::sample_t push_sample,
  input  logic              pop,
  output pwsr_pkg::sample_t pop_sample,
  output logic              full,
  output logic              empty
);

  pwsr_pkg::sample_t                  entries [pwsr_pkg::QUEUE_DEPTH];
  logic [pwsr_pkg::QPTR_W-1:0]        wr_ptr;
  logic [pwsr_pkg::QPTR_W-1:0]        rd_ptr;
  logic [pwsr_pkg::QPTR_W:0]          fill;

  assign full       = (fill == (pwsr_pkg::QPTR_W+1)'(pwsr_pkg::QUEUE_DEPTH));
  assign empty      = (fill == '0);
  assign pop_sample = entries[rd_ptr];

  // Store incoming samples
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_sample;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/pwsr_back.sv =====
// ----------------------------------------------------------------------------
// pwsr_back: pulse width decoder
// Takes one classified sample per cycle unless the queue is empty or a
// result stalls; measures run lengths, learns the bit threshold from the two
// reference pulses and assembles bytes into a registered output stage.
// ----------------------------------------------------------------------------
module pwsr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        max_bytes,
  input  logic [7:0]        max_run,
  input  logic              queue_empty,
  input  pwsr_pkg::sample_t pop_sample,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        data_byte,
  output logic              is_last,
  output logic              frame_error
);

  logic [2:0] phase, phase_next;
  logic [7:0] run_count, run_count_next;
  logic [7:0] zero_reference, zero_reference_next;
  logic [7:0] threshold, threshold_next;
  logic [3:0] bit_position, bit_position_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] byte_count, byte_count_next;

  logic       res_valid;
  logic [7:0] res_byte;
  logic       res_last;
  logic       res_err;
  logic       ok;
  logic       extend;
  logic       begin_run;
  logic       pulse_bit;
  logic       last;
  logic [8:0] ref_sum;
  logic [7:0] byte_count_inc;

  // Take a sample when the output stage can hold a result
  assign pop = ~queue_empty & (~out_valid | ~out_stall);

  assign ref_sum        = {1'b0, zero_reference} + {1'b0, run_count};
  assign pulse_bit      = (run_count > threshold);
  assign byte_count_inc = byte_count + 8'd1;
  assign last           = pulse_bit | (byte_count_inc >= max_bytes);

  // Decode one sample
  always_comb begin
    phase_next          = phase;
    run_count_next      = run_count;
    zero_reference_next = zero_reference;
    threshold_next      = threshold;
    bit_position_next   = bit_position;
    shift_byte_next     = shift_byte;
    byte_count_next     = byte_count;
    res_valid           = 1'b0;
    res_byte            = shift_byte;
    res_last            = 1'b0;
    res_err             = 1'b0;
    ok                  = 1'b1;
    extend              = 1'b0;
    begin_run           = 1'b0;

    case (phase)
      pwsr_pkg::PH_LEAD_LOW, pwsr_pkg::PH_REF0_GAP, pwsr_pkg::PH_BIT_GAP: begin
        if (!pop_sample.level) begin
          extend = 1'b1;
        end else begin
          phase_next = phase + 3'd1;
          begin_run  = 1'b1;
        end
      end
      pwsr_pkg::PH_REF0_HIGH, pwsr_pkg::PH_REF1_HIGH, pwsr_pkg::PH_BIT_HIGH: begin
        if (pop_sample.level) begin
          extend = 1'b1;
        end else if (phase == pwsr_pkg::PH_REF0_HIGH) begin
          zero_reference_next = run_count;
          phase_next          = pwsr_pkg::PH_REF0_GAP;
          begin_run           = 1'b1;
        end else if (phase == pwsr_pkg::PH_REF1_HIGH) begin
          threshold_next    = ref_sum[8:1];
          bit_position_next = '0;
          shift_byte_next   = '0;
          byte_count_next   = '0;
          phase_next        = pwsr_pkg::PH_BIT_GAP;
          begin_run         = 1'b1;
        end else if (bit_position < pwsr_pkg::BITS_PER_BYTE) begin
          shift_byte_next   = {shift_byte[6:0], pulse_bit};
          bit_position_next = bit_position + 4'd1;
          phase_next        = pwsr_pkg::PH_BIT_GAP;
          begin_run         = 1'b1;
        end else begin
          // Flag pulse: emit the byte
          byte_count_next   = byte_count_inc;
          res_valid         = 1'b1;
          res_byte          = shift_byte;
          res_last          = last;
          bit_position_next = '0;
          shift_byte_next   = '0;
          if (last) begin
            phase_next = pwsr_pkg::PH_IDLE;
          end else begin
            phase_next = pwsr_pkg::PH_BIT_GAP;
            begin_run  = 1'b1;
          end
        end
      end
      default: begin
        phase_next = pwsr_pkg::PH_IDLE;
        if (pop_sample.fall) begin
          phase_next = pwsr_pkg::PH_LEAD_LOW;
          begin_run  = 1'b1;
        end
      end
    endcase

    // Lengthen or restart the current run, watching for timeout
    if (extend) begin
      if (run_count >= max_run) begin
        ok = 1'b0;
      end else begin
        run_count_next = run_count + 8'd1;
      end
    end
    if (begin_run) begin
      run_count_next = '0;
      if (max_run == '0) begin
        ok = 1'b0;
      end else begin
        run_count_next = 8'd1;
      end
    end

    // Abort the frame on timeout
    if (!ok) begin
      phase_next = pwsr_pkg::PH_IDLE;
      res_valid  = 1'b1;
      res_byte   = '0;
      res_last   = 1'b1;
      res_err    = 1'b1;
    end
  end

  // Decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= pwsr_pkg::PH_IDLE;
      run_count      <= '0;
      zero_reference <= '0;
      threshold      <= '0;
      bit_position   <= '0;
      shift_byte     <= '0;
      byte_count     <= '0;
    end else if (pop) begin
      phase          <= phase_next;
      run_count      <= run_count_next;
      zero_reference <= zero_reference_next;
      threshold      <= threshold_next;
      bit_position   <= bit_position_next;
      shift_byte     <= shift_byte_next;
      byte_count     <= byte_count_next;
    end
  end

  // Output stage: load a result, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      data_byte   <= res_byte;
      is_last     <= res_last;
      frame_error <= res_err;
    end
  end

  // Checks
  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_error) |-> is_last)
    else $error("error result not marked last");

  a_error_zero_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_error) |-> (data_byte == '0))
    else $error("error result carries data");

  a_abort_to_idle: assert property (@(posedge clk) disable iff (rst)
    (pop && !ok) |=> (phase == pwsr_pkg::PH_IDLE))
    else $error("decoder not idle after abort");

  a_bit_position_range: assert property (@(posedge clk) disable iff (rst)
    bit_position <= pwsr_pkg::BITS_PER_BYTE)
    else $error("bit position out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result lost");

endmodule

// ===== rtl/core/pulse_width_serial_receiver_top.sv =====
// ----------------------------------------------------------------------------
// pulse_width_serial_receiver_top: single-wire pulse width receiver
//
// Input channel (in_valid/in_stall, line_level) carries one line sample per
// transfer. A high-to-low edge in idle starts a frame; two high reference
// pulses set the threshold, then each high pulse is a bit, eight bits MSB
// first plus a flag pulse per byte.
// Output channel (out_valid/out_stall, data_byte, is_last, frame_error)
// carries one result per byte, or an error result on a run timeout.
// Configuration: cfg_we writes cfg_data into max_bytes (index 0) or
// max_run (index 1); write only while no frame is in progress.
// Throughput: one sample per clock while the queue has room; the decoder
// handles one queued sample per cycle, but pauses while out_stall holds a
// result, so the 4-entry sample queue between intake and decoder fills
// and in_stall rises once it is full. A result is registered in the output
// stage when the decoder pops the sample that completes it.
// Reset: synchronous; clears the queue and output stage, returns the decoder
// to idle with the line taken as high, and loads max_bytes 32, max_run 255.
// ----------------------------------------------------------------------------
module pulse_width_serial_receiver_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       line_level,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] data_byte,
  output logic       is_last,
  output logic       frame_error
);

  logic [7:0]        max_bytes;
  logic [7:0]        max_run;
  logic              push;
  logic              pop;
  logic              queue_full;
  logic              queue_empty;
  pwsr_pkg::sample_t push_sample;
  pwsr_pkg::sample_t pop_sample;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= pwsr_pkg::MAX_BYTES_RESET;
      max_run   <= pwsr_pkg::MAX_RUN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pwsr_pkg::CFG_MAX_BYTES: max_bytes <= cfg_data;
        pwsr_pkg::CFG_MAX_RUN:   max_run   <= cfg_data;
        default: ;
      endcase
    end
  end

  pwsr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .line_level  (line_level),
    .queue_full  (queue_full),
    .push        (push),
    .push_sample (push_sample)
  );

  pwsr_queue u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_sample (push_sample),
    .pop         (pop),
    .pop_sample  (pop_sample),
    .full        (queue_full),
    .empty       (queue_empty)
  );

  pwsr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .max_bytes   (max_bytes),
    .max_run     (max_run),
    .queue_empty (queue_empty),
    .pop_sample  (pop_sample),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .data_byte   (data_byte),
    .is_last     (is_last),
    .frame_error (frame_error)
  );

endmodule
